FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

FILE: design/icmpenc_pkg.sv
// ----------------------------------------------------------------------------
// icmpenc_pkg
// Shared types, constants and helpers of the ICMP echo encapsulator.
// ----------------------------------------------------------------------------
package icmpenc_pkg;

  // Inner header store
  localparam int unsigned HDR_DEPTH = 20;
  localparam int unsigned HDR_AW    = $clog2(HDR_DEPTH);

  // Outer IP header plus ICMP header
  localparam int unsigned TAIL_LEN = 28;
  localparam int unsigned TAIL_AW  = $clog2(TAIL_LEN);

  localparam logic [15:0] WRAP_HDR_LEN = 16'(TAIL_LEN);
  localparam logic [15:0] MAX_PAYLOAD  = 16'd65506;

  // Output queue
  localparam int unsigned OUT_FIFO_DEPTH = 2;
  localparam int unsigned OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned OUT_FIFO_CW    = $clog2(OUT_FIFO_DEPTH + 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_REPLY   = 1'b1;

  // Protocol codes
  localparam logic [3:0] IHL_MIN           = 4'd5;
  localparam logic [7:0] IP_PROTO_ICMP     = 8'd1;
  localparam logic [7:0] ICMP_TYPE_REQUEST = 8'd8;
  localparam logic [7:0] ICMP_TYPE_REPLY   = 8'd0;

  // Byte positions within the wrapped packet's headers
  localparam logic [TAIL_AW-1:0] OFS_VER_IHL   = 5'd0;
  localparam logic [TAIL_AW-1:0] OFS_LEN_HI    = 5'd2;
  localparam logic [TAIL_AW-1:0] OFS_LEN_LO    = 5'd3;
  localparam logic [TAIL_AW-1:0] OFS_PROTO     = 5'd9;
  localparam logic [TAIL_AW-1:0] OFS_IPCSUM_HI = 5'd10;
  localparam logic [TAIL_AW-1:0] OFS_IPCSUM_LO = 5'd11;
  localparam logic [TAIL_AW-1:0] OFS_DST0      = 5'd16;
  localparam logic [TAIL_AW-1:0] OFS_DST1      = 5'd17;
  localparam logic [TAIL_AW-1:0] OFS_DST2      = 5'd18;
  localparam logic [TAIL_AW-1:0] OFS_DST3      = 5'd19;
  localparam logic [TAIL_AW-1:0] OFS_ICMP_TYPE = 5'd20;
  localparam logic [TAIL_AW-1:0] OFS_ICMP_CS_HI = 5'd22;
  localparam logic [TAIL_AW-1:0] OFS_ICMP_CS_LO = 5'd23;
  localparam logic [TAIL_AW-1:0] TAIL_LAST     = 5'(TAIL_LEN - 1);

  // Checksum completion steps run during the tail
  localparam logic [2:0] STEP_TOTAL = 3'd0;
  localparam logic [2:0] STEP_DHI   = 3'd1;
  localparam logic [2:0] STEP_DLO   = 3'd2;
  localparam logic [2:0] STEP_CONST = 3'd3;
  localparam logic [2:0] STEP_DONE  = 3'd4;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_PAD,
    ST_HDR
  } state_t;

  typedef struct packed {
    logic [15:0] byte_offset;
    logic [7:0]  out_byte;
    logic        packet_done;
    logic        too_long;
  } result_t;

  // One's-complement 16-bit add with end-around carry
  function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Inner header bytes that enter the outer checksum unchanged (or masked)
  function automatic logic hdr_byte_kept(logic [TAIL_AW-1:0] idx);
    logic kept;
    case (idx)
      OFS_LEN_HI, OFS_LEN_LO, OFS_PROTO, OFS_IPCSUM_HI, OFS_IPCSUM_LO,
      OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3: kept = 1'b0;
      default: kept = 1'b1;
    endcase
    return kept;
  endfunction

endpackage

FILE: design/icmpenc_out_fifo.sv
// ----------------------------------------------------------------------------
// icmpenc_out_fifo
// Two-entry result queue that decouples the encapsulator from the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icmpenc_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  icmpenc_pkg::result_t push_data,
  output logic                 space,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output icmpenc_pkg::result_t pop_data
);

  icmpenc_pkg::result_t                     entries [icmpenc_pkg::OUT_FIFO_DEPTH];
  logic [icmpenc_pkg::OUT_FIFO_AW-1:0]      wr_ptr;
  logic [icmpenc_pkg::OUT_FIFO_AW-1:0]      rd_ptr;
  logic [icmpenc_pkg::OUT_FIFO_CW-1:0]      count;
  logic                                     pop;

  assign space     = (count != icmpenc_pkg::OUT_FIFO_CW'(icmpenc_pkg::OUT_FIFO_DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_push_full, push && !space)
  `ASSERT_CLK(a_count_range, count <= icmpenc_pkg::OUT_FIFO_CW'(icmpenc_pkg::OUT_FIFO_DEPTH))
  `ASSERT_CLK(a_empty_stable, (!pop_valid && !push) |=> !pop_valid)

endmodule

FILE: design/icmp_echo_encapsulator.sv
// ----------------------------------------------------------------------------
// icmp_echo_encapsulator
// Wraps an inner IPv4 packet, byte by byte, into an ICMP echo message.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the inner packet one byte per word, tlast on its last byte.
//   m_axis carries (offset, byte) pairs of the wrapped packet: every payload
//   byte goes out at offset 28 + index through the output queue, then the
//   tail follows: a zero pad byte when the length is odd, the 20-byte outer
//   IPv4 header (offsets 0..19) and the 8-byte ICMP header (offsets 20..27).
//   tlast marks the last word of the tail; tuser marks the tail words of a
//   packet whose bytes past 65506 were dropped.
//   Throughput: one byte per cycle while the payload streams and the output
//   queue has space. After tlast the tail sequencer reads the header memory
//   once, emitting the pad byte in that step when present, then sends the 28
//   header words; no input is taken meanwhile.
//   A two-word output queue lets input continue while one result waits; a
//   stalled receiver holds everything once the queue is full.
//   Reset clears all packet state and sets dest_address and echo_reply to 0.
//   Configuration is written through cfg_we/cfg_index/cfg_data when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icmp_echo_encapsulator (
  input  logic                              clk,
  input  logic                              rst,
  // Inner packet
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  logic                              s_axis_tlast,   // final_byte
  // Wrapped packet words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,   // [15:0] byte_offset, [23:16] out_byte
  output logic                              m_axis_tlast,   // packet_done
  output logic                              m_axis_tuser,   // too_long
  // Configuration
  input  logic                              cfg_we,
  input  logic [icmpenc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                       cfg_data
);

  // Configuration registers
  logic [31:0] dest_address;
  logic        echo_reply;

  // Packet state
  icmpenc_pkg::state_t state, state_next;
  logic [15:0] byte_count;
  logic [15:0] payload_sum;
  logic [15:0] hdr_sum;
  logic [7:0]  pending_high_byte;
  logic        overflow_seen;
  logic [icmpenc_pkg::HDR_DEPTH-1:0] hdr_valid;
  logic [15:0] total;
  logic        len_odd;
  logic [icmpenc_pkg::TAIL_AW-1:0] tail_idx;
  logic [2:0]  sum_step;

  // Header memory
  logic [7:0]  hdr_mem [icmpenc_pkg::HDR_DEPTH];
  logic [7:0]  rd_data;
  logic        rd_valid;
  logic        rd_en;
  logic [icmpenc_pkg::HDR_AW-1:0] rd_addr;

  // Datapath
  logic        fifo_space;
  logic        in_accept;
  logic        in_keep;
  logic        in_hdr;
  logic [icmpenc_pkg::HDR_AW-1:0] wr_addr;
  logic [15:0] len;
  logic [15:0] total_in;
  logic [7:0]  hdr_in_byte;
  logic [15:0] hdr_add;
  logic [15:0] pay_add;
  logic [7:0]  icmp_type;
  logic [7:0]  hbyte;
  logic [7:0]  tail_byte;
  logic        tail_push;
  logic        stream_push;
  logic        pkt_clear;
  logic        fifo_push;
  icmpenc_pkg::result_t fifo_in;
  icmpenc_pkg::result_t fifo_out;

  assign icmp_type = echo_reply ? icmpenc_pkg::ICMP_TYPE_REPLY : icmpenc_pkg::ICMP_TYPE_REQUEST;

  // Input handshake
  assign s_axis_tready = (state == icmpenc_pkg::ST_STREAM) && fifo_space;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_keep       = byte_count < icmpenc_pkg::MAX_PAYLOAD;
  assign in_hdr        = byte_count < 16'(icmpenc_pkg::HDR_DEPTH);
  assign wr_addr       = byte_count[icmpenc_pkg::HDR_AW-1:0];
  assign stream_push   = in_accept && in_keep;

  // Length and outer total length as seen at the final byte
  assign len      = byte_count + {15'd0, in_keep};
  assign total_in = icmpenc_pkg::WRAP_HDR_LEN + len + {15'd0, len[0]};

  // Header byte as it enters the outer checksum
  assign hdr_in_byte = (wr_addr == icmpenc_pkg::HDR_AW'(icmpenc_pkg::OFS_VER_IHL)) ?
                       {s_axis_tdata[7:4], 4'd0} : s_axis_tdata;

  // Checksum adder operands: streaming bytes, then completion steps
  always_comb begin
    hdr_add = '0;
    pay_add = '0;
    if (state == icmpenc_pkg::ST_STREAM) begin
      if (stream_push && in_hdr &&
          icmpenc_pkg::hdr_byte_kept(icmpenc_pkg::TAIL_AW'(wr_addr))) begin
        hdr_add = byte_count[0] ? {8'd0, hdr_in_byte} : {hdr_in_byte, 8'd0};
      end
      if (stream_push && byte_count[0]) begin
        pay_add = {pending_high_byte, s_axis_tdata};
      end
    end else begin
      case (sum_step)
        icmpenc_pkg::STEP_TOTAL: begin
          hdr_add = total;
          pay_add = len_odd ? {pending_high_byte, 8'd0} : 16'd0;
        end
        icmpenc_pkg::STEP_DHI: begin
          hdr_add = dest_address[31:16];
          pay_add = {icmp_type, 8'd0};
        end
        icmpenc_pkg::STEP_DLO: begin
          hdr_add = dest_address[15:0];
        end
        icmpenc_pkg::STEP_CONST: begin
          hdr_add = {4'd0, icmpenc_pkg::IHL_MIN, icmpenc_pkg::IP_PROTO_ICMP};
        end
        default: begin
          hdr_add = '0;
        end
      endcase
    end
  end

  // Header byte of the current tail position
  assign hbyte = rd_valid ? rd_data : 8'd0;

  always_comb begin
    case (tail_idx)
      icmpenc_pkg::OFS_VER_IHL:    tail_byte = {hbyte[7:4], icmpenc_pkg::IHL_MIN};
      icmpenc_pkg::OFS_LEN_HI:     tail_byte = total[15:8];
      icmpenc_pkg::OFS_LEN_LO:     tail_byte = total[7:0];
      icmpenc_pkg::OFS_PROTO:      tail_byte = icmpenc_pkg::IP_PROTO_ICMP;
      icmpenc_pkg::OFS_IPCSUM_HI:  tail_byte = ~hdr_sum[15:8];
      icmpenc_pkg::OFS_IPCSUM_LO:  tail_byte = ~hdr_sum[7:0];
      icmpenc_pkg::OFS_DST0:       tail_byte = dest_address[31:24];
      icmpenc_pkg::OFS_DST1:       tail_byte = dest_address[23:16];
      icmpenc_pkg::OFS_DST2:       tail_byte = dest_address[15:8];
      icmpenc_pkg::OFS_DST3:       tail_byte = dest_address[7:0];
      icmpenc_pkg::OFS_ICMP_TYPE:  tail_byte = icmp_type;
      icmpenc_pkg::OFS_ICMP_CS_HI: tail_byte = ~payload_sum[15:8];
      icmpenc_pkg::OFS_ICMP_CS_LO: tail_byte = ~payload_sum[7:0];
      default: begin
        tail_byte = (tail_idx < icmpenc_pkg::TAIL_AW'(icmpenc_pkg::HDR_DEPTH)) ? hbyte : 8'd0;
      end
    endcase
  end

  // Tail sequencer: next state, memory reads and result selection
  always_comb begin
    state_next  = state;
    rd_en       = 1'b0;
    rd_addr     = '0;
    tail_push   = 1'b0;
    pkt_clear   = 1'b0;
    fifo_in     = '{byte_offset: icmpenc_pkg::WRAP_HDR_LEN + byte_count,
                    out_byte:    s_axis_tdata,
                    packet_done: 1'b0,
                    too_long:    overflow_seen};
    case (state)
      icmpenc_pkg::ST_STREAM: begin
        if (in_accept && s_axis_tlast) begin
          state_next = icmpenc_pkg::ST_PAD;
        end
      end
      icmpenc_pkg::ST_PAD: begin
        rd_en   = 1'b1;
        fifo_in = '{byte_offset: total - 16'd1,
                    out_byte:    8'd0,
                    packet_done: 1'b0,
                    too_long:    overflow_seen};
        if (!len_odd) begin
          state_next = icmpenc_pkg::ST_HDR;
        end else if (fifo_space) begin
          tail_push  = 1'b1;
          state_next = icmpenc_pkg::ST_HDR;
        end
      end
      icmpenc_pkg::ST_HDR: begin
        fifo_in = '{byte_offset: {{(16 - icmpenc_pkg::TAIL_AW){1'b0}}, tail_idx},
                    out_byte:    tail_byte,
                    packet_done: (tail_idx == icmpenc_pkg::TAIL_LAST),
                    too_long:    overflow_seen};
        if (fifo_space) begin
          tail_push = 1'b1;
          rd_addr   = icmpenc_pkg::HDR_AW'(tail_idx + 1'b1);
          rd_en     = (tail_idx + 1'b1) < icmpenc_pkg::TAIL_AW'(icmpenc_pkg::HDR_DEPTH);
          if (tail_idx == icmpenc_pkg::TAIL_LAST) begin
            pkt_clear  = 1'b1;
            state_next = icmpenc_pkg::ST_STREAM;
          end
        end
      end
      default: begin
        state_next = icmpenc_pkg::ST_STREAM;
      end
    endcase
  end

  assign fifo_push = stream_push || tail_push;

  // Header memory: written while streaming, read by the tail
  always_ff @(posedge clk) begin
    if (stream_push && in_hdr) begin
      hdr_mem[wr_addr] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data  <= hdr_mem[rd_addr];
      rd_valid <= hdr_valid[rd_addr];
    end
  end

  // Control and packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= icmpenc_pkg::ST_STREAM;
      byte_count        <= '0;
      payload_sum       <= '0;
      hdr_sum           <= '0;
      pending_high_byte <= '0;
      overflow_seen     <= 1'b0;
      hdr_valid         <= '0;
      tail_idx          <= '0;
      sum_step          <= icmpenc_pkg::STEP_TOTAL;
      total             <= '0;
      len_odd           <= 1'b0;
    end else begin
      state <= state_next;
      if (pkt_clear) begin
        byte_count        <= '0;
        payload_sum       <= '0;
        hdr_sum           <= '0;
        pending_high_byte <= '0;
        overflow_seen     <= 1'b0;
        hdr_valid         <= '0;
      end else begin
        payload_sum <= icmpenc_pkg::ones_add(payload_sum, pay_add);
        hdr_sum     <= icmpenc_pkg::ones_add(hdr_sum, hdr_add);
        if (stream_push) begin
          byte_count <= byte_count + 16'd1;
          if (!byte_count[0]) begin
            pending_high_byte <= s_axis_tdata;
          end
          if (in_hdr) begin
            hdr_valid[wr_addr] <= 1'b1;
          end
        end
        if (in_accept && !in_keep) begin
          overflow_seen <= 1'b1;
        end
      end
      // Tail bookkeeping
      if (in_accept && s_axis_tlast) begin
        total    <= total_in;
        len_odd  <= len[0];
        tail_idx <= '0;
        sum_step <= icmpenc_pkg::STEP_TOTAL;
      end else begin
        if (state != icmpenc_pkg::ST_STREAM && sum_step != icmpenc_pkg::STEP_DONE) begin
          sum_step <= sum_step + 3'd1;
        end
        if (state == icmpenc_pkg::ST_HDR && tail_push) begin
          tail_idx <= tail_idx + 1'b1;
        end
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= '0;
      echo_reply   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        icmpenc_pkg::CFG_DEST_ADDRESS: dest_address <= cfg_data;
        icmpenc_pkg::CFG_ECHO_REPLY:   echo_reply   <= cfg_data[0];
        default: begin
          dest_address <= dest_address;
        end
      endcase
    end
  end

  // Result queue
  icmpenc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_in),
    .space     (fifo_space),
    .pop_valid (m_axis_tvalid),
    .pop_ready (m_axis_tready),
    .pop_data  (fifo_out)
  );

  assign m_axis_tdata = {fifo_out.out_byte, fifo_out.byte_offset};
  assign m_axis_tlast = fifo_out.packet_done;
  assign m_axis_tuser = fifo_out.too_long;

  `ASSERT_NEVER(a_no_input_in_tail, (state != icmpenc_pkg::ST_STREAM) && in_accept)
  `ASSERT_CLK(a_csum_ready,
    (tail_push && state == icmpenc_pkg::ST_HDR && tail_idx == icmpenc_pkg::OFS_IPCSUM_HI)
    |-> (sum_step == icmpenc_pkg::STEP_DONE))
  `ASSERT_CLK(a_clear_after_tail,
    pkt_clear |=> (hdr_valid == '0) && (byte_count == '0) && (state == icmpenc_pkg::ST_STREAM))
  `ASSERT_CLK(a_count_bound, byte_count <= icmpenc_pkg::MAX_PAYLOAD)

endmodule
